// ===== rtl/core/signed_unsigned_divider_64_defines.svh =====
// Assertion macros for the divider checker.
`ifndef SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH
`define SIGNED_UNSIGNED_DIVIDER_64_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define SUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");

// Implication that must hold a fixed number of cycles later.
`define SUD_ASSERT_AFTER(label, clk, rst_n, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("divider check failed");

`endif

// ===== rtl/core/sud_pkg.sv =====
`timescale 1ns / 1ps

package sud_pkg;

    localparam int OPER_W = 64;
    localparam int MODE_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_UQUO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UREM = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUO = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SREM = 2'd3;

    typedef struct packed {
        logic [OPER_W-1:0] dividend;
        logic [OPER_W-1:0] divisor;
        logic [MODE_W-1:0] mode;
    } in_item_t;

    typedef struct packed {
        logic [OPER_W-1:0] result;
        logic              divide_by_zero;
    } out_item_t;

    // Control that travels alongside the data through the cell chain
    typedef struct packed {
        logic valid;
        logic want_rem;
        logic neg_res;
        logic dbz;
    } ctrl_t;

endpackage

// ===== rtl/core/sud_cell.sv =====
`timescale 1ns / 1ps

module sud_cell #(
    parameter int WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sud_pkg::ctrl_t     ctrl_in,
    input  logic [WIDTH-1:0]   rem_in,
    input  logic [WIDTH-1:0]   nq_in,
    input  logic [WIDTH-1:0]   den_in,
    output sud_pkg::ctrl_t     ctrl_out,
    output logic [WIDTH-1:0]   rem_out,
    output logic [WIDTH-1:0]   nq_out,
    output logic [WIDTH-1:0]   den_out
);

    // nq holds the unconsumed dividend bits on top and quotient bits below
    logic [WIDTH+1:0] trial;
    logic             fits;
    logic [WIDTH-1:0] shifted;

    sud_pkg::ctrl_t   ctrl_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] nq_reg;
    logic [WIDTH-1:0] den_reg;

    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] nq_next;

    always_comb
    begin
        shifted  = {rem_in[WIDTH-2:0], nq_in[WIDTH-1]};
        trial    = {1'b0, rem_in, nq_in[WIDTH-1]} - {2'b00, den_in};
        fits     = ~trial[WIDTH+1];
        rem_next = fits ? trial[WIDTH-1:0] : shifted;
        nq_next  = {nq_in[WIDTH-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        nq_reg  <= nq_next;
        den_reg <= den_in;
    end

    assign ctrl_out = ctrl_reg;
    assign rem_out  = rem_reg;
    assign nq_out   = nq_reg;
    assign den_out  = den_reg;

endmodule

// ===== rtl/core/signed_unsigned_divider_64.sv =====
// Throughput: one transaction per cycle; busy stays low, a new transaction may follow
// every clock. A registered front stage feeds a chain of WIDTH restoring cells, one
// quotient bit each, and the chain feeds a registered back stage that drives done.
// Reset (rst_n low, asynchronous) drops every transaction in flight; done stays low
// until a transaction accepted after reset reaches the end of the chain.
`timescale 1ns / 1ps

module signed_unsigned_divider_64 #(
    parameter int WIDTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  sud_pkg::in_item_t    cmd,
    output logic                 done,
    output sud_pkg::out_item_t   rsp
);

    // ---------------------------------------------------------------
    // Front stage: take magnitudes, flag a zero divisor, work out the
    // sign of the final result.
    // ---------------------------------------------------------------
    logic [WIDTH-1:0] a_raw;
    logic [WIDTH-1:0] b_raw;
    logic             is_signed;
    logic             want_rem;
    logic             a_neg;
    logic             b_neg;
    logic [WIDTH-1:0] a_mag;
    logic [WIDTH-1:0] b_mag;
    sud_pkg::ctrl_t   ctrl_next;

    sud_pkg::ctrl_t   ctrl_reg;
    logic [WIDTH-1:0] nq_reg;
    logic [WIDTH-1:0] den_reg;

    always_comb
    begin
        a_raw     = cmd.dividend[WIDTH-1:0];
        b_raw     = cmd.divisor[WIDTH-1:0];
        is_signed = (cmd.mode == sud_pkg::MODE_SQUO) || (cmd.mode == sud_pkg::MODE_SREM);
        want_rem  = (cmd.mode == sud_pkg::MODE_UREM) || (cmd.mode == sud_pkg::MODE_SREM);
        a_neg     = is_signed & a_raw[WIDTH-1];
        b_neg     = is_signed & b_raw[WIDTH-1];
        a_mag     = a_neg ? (~a_raw + 1'b1) : a_raw;
        b_mag     = b_neg ? (~b_raw + 1'b1) : b_raw;

        ctrl_next.valid    = start & ~busy;
        ctrl_next.want_rem = want_rem;
        // Remainder follows the dividend's sign; quotient negates on differing signs
        ctrl_next.neg_res  = want_rem ? a_neg : (a_neg ^ b_neg);
        ctrl_next.dbz      = (b_raw == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nq_reg  <= a_mag;
        den_reg <= b_mag;
    end

    // ---------------------------------------------------------------
    // Cell chain: stage i holds the transaction after i restoring steps.
    // The partial remainder starts at zero.
    // ---------------------------------------------------------------
    sud_pkg::ctrl_t   ctrl_stage [WIDTH+1];
    logic [WIDTH-1:0] rem_stage  [WIDTH+1];
    logic [WIDTH-1:0] nq_stage   [WIDTH+1];
    logic [WIDTH-1:0] den_stage  [WIDTH+1];

    assign ctrl_stage[0] = ctrl_reg;
    assign rem_stage[0]  = '0;
    assign nq_stage[0]   = nq_reg;
    assign den_stage[0]  = den_reg;

    for (genvar i = 0; i < WIDTH; i++)
    begin : g_cell
        sud_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_stage[i]),
            .rem_in   (rem_stage[i]),
            .nq_in    (nq_stage[i]),
            .den_in   (den_stage[i]),
            .ctrl_out (ctrl_stage[i+1]),
            .rem_out  (rem_stage[i+1]),
            .nq_out   (nq_stage[i+1]),
            .den_out  (den_stage[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Back stage: pick quotient or remainder, fix the sign, force zero
    // on a zero divisor, and drive the one-cycle result strobe.
    // ---------------------------------------------------------------
    sud_pkg::ctrl_t     ctrl_last;
    logic [WIDTH-1:0]   sel;
    logic [WIDTH-1:0]   signed_res;
    sud_pkg::out_item_t rsp_next;
    logic               done_reg;
    sud_pkg::out_item_t rsp_reg;

    always_comb
    begin
        ctrl_last  = ctrl_stage[WIDTH];
        sel        = ctrl_last.want_rem ? rem_stage[WIDTH] : nq_stage[WIDTH];
        signed_res = ctrl_last.neg_res ? (~sel + 1'b1) : sel;

        rsp_next.result         = ctrl_last.dbz ? '0 : (sud_pkg::OPER_W)'(signed_res);
        rsp_next.divide_by_zero = ctrl_last.dbz;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    // The pipeline never stalls, so a new transaction is always welcome
    assign busy = 1'b0;
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/core/sud_checker.sv =====
`timescale 1ns / 1ps
`include "signed_unsigned_divider_64_defines.svh"

module sud_checker #(
    parameter int WIDTH = 64
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input sud_pkg::in_item_t    cmd,
    input logic                 done,
    input sud_pkg::out_item_t   rsp
);

    localparam int LAT = WIDTH + 2;

    logic [sud_pkg::OPER_W-1:0] high_mask;

    assign high_mask = ~((sud_pkg::OPER_W)'({WIDTH{1'b1}}));

    `SUD_ASSERT_AFTER(a_accept_to_done, clk, rst_n, start && !busy, LAT, done)
    `SUD_ASSERT_NOW(a_done_from_accept, clk, rst_n, done, $past(start && !busy, LAT))
    `SUD_ASSERT_NOW(a_dbz_zero, clk, rst_n, done && rsp.divide_by_zero, rsp.result == '0)
    `SUD_ASSERT_NOW(a_high_bits_zero, clk, rst_n, done, (rsp.result & high_mask) == '0)
    `SUD_ASSERT_AFTER(a_dbz_flag, clk, rst_n, start && !busy, LAT, rsp.divide_by_zero == $past(cmd.divisor[WIDTH-1:0] == '0, LAT))

endmodule

bind signed_unsigned_divider_64 sud_checker #(
    .WIDTH (WIDTH)
) u_sud_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .rsp   (rsp)
);
